[src/stk_pkg.sv]
// Shared types and codes for the bounded stack with search.
package stk_pkg;

	localparam int DefDepth = 16;
	localparam int MaxShow = 16;

	localparam logic [2:0] REQ_PUSH = 3'd0;
	localparam logic [2:0] REQ_POP = 3'd1;
	localparam logic [2:0] REQ_PEEK = 3'd2;
	localparam logic [2:0] REQ_SHOW = 3'd3;
	localparam logic [2:0] REQ_SEARCH = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] data;
		logic [3:0] position;
		logic empty_res;
		logic last;
	} res_t;

endpackage

[src/stk_mem.sv]
// Stack word memory: one write port, one read port with registered read data.
module stk_mem import stk_pkg::*; #(
	parameter int DEPTH = DefDepth,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic signed [31:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last word read until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/stk_oreg.sv]
// Output register that holds one result item until the consumer takes it.
module stk_oreg import stk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input res_t res_in,
	input logic out_stall,
	output logic out_valid,
	output logic can_load,
	output res_t res_q
);

	logic valid_q;

	assign can_load = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_in;
		end
	end

endmodule

[src/bounded_stack_with_search_unit.sv]
// Top level of the bounded stack with search: request decode, scan sequencer, memory.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | req_type, value
//   out     | out_valid / out_stall| status, data, position, empty_res, last
//
// Push, overflow and empty-stack requests are answered at acceptance. Pop and
// peek go through accept, memory read and result. Show reads up to MaxShow words,
// search up to the word count; the single read port of the stack memory walks
// one slot per cycle. Reset clears the word count and scan state; memory holds
// garbage until written. A stalled output holds its item and pauses the scan.
module bounded_stack_with_search_unit import stk_pkg::*; #(
	parameter int DEPTH = DefDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] req_type,
	input logic signed [31:0] value,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic signed [31:0] data,
	output logic [3:0] position,
	output logic empty_res,
	output logic last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] ptr_q;
	logic down_q;
	logic search_q;
	logic signed [31:0] key_q;
	logic pend_q;
	logic [AW-1:0] pend_slot_s1;
	logic pend_last_s1;

	logic acc;
	logic can_emit;
	logic load;
	res_t res_in;
	res_t res_q;
	logic signed [31:0] rdata;
	logic mem_we;
	logic mem_re;
	logic [CW-1:0] cnt_dec;
	logic is_empty;
	logic is_full;
	logic match;
	logic need_emit;
	logic consume;
	logic done;
	logic emit_idle;
	res_t res_idle;

	assign is_empty = (count_q == '0);
	assign is_full = (32'(count_q) == DEPTH);
	assign cnt_dec = count_q - CW'(1);

	assign in_stall = !(state_q == S_IDLE && can_emit);
	assign acc = in_valid && !in_stall;

	// scan engine
	assign match = (rdata == key_q);
	assign need_emit = !search_q || match || pend_last_s1;
	assign consume = (state_q == S_SCAN) && pend_q && (!need_emit || can_emit);
	assign done = consume && (search_q ? (match || pend_last_s1) : pend_last_s1);
	assign mem_re = (state_q == S_SCAN) && (rem_q != '0) && (!pend_q || consume) && !done;
	assign mem_we = acc && req_type == REQ_PUSH && !is_full;

	// results decided at acceptance
	always_comb begin
		emit_idle = 1'b0;
		res_idle.status = ST_OK;
		res_idle.data = '0;
		res_idle.position = '0;
		res_idle.empty_res = is_empty;
		res_idle.last = 1'b1;
		if (acc) begin
			case (req_type)
				REQ_PUSH: begin
					emit_idle = 1'b1;
					if (is_full) begin
						res_idle.status = ST_OVERFLOW;
					end else begin
						res_idle.data = value;
						res_idle.position = 4'(count_q);
						res_idle.empty_res = 1'b0;
					end
				end
				REQ_POP, REQ_PEEK, REQ_SHOW, REQ_SEARCH: begin
					if (is_empty) begin
						emit_idle = 1'b1;
						res_idle.status = ST_UNDERFLOW;
					end
				end
				default: begin
					emit_idle = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		if (emit_idle) begin
			res_in = res_idle;
		end else begin
			res_in.status = (search_q && !match) ? ST_NOTFOUND : ST_OK;
			res_in.data = (search_q && !match) ? 32'sd0 : rdata;
			res_in.position = (search_q && !match) ? 4'd0 : 4'(pend_slot_s1);
			res_in.empty_res = is_empty;
			res_in.last = search_q || pend_last_s1;
		end
	end

	assign load = emit_idle || (consume && need_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q <= '0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && !is_empty) begin
						case (req_type)
							REQ_POP: begin
								count_q <= cnt_dec;
								rem_q <= CW'(1);
								state_q <= S_SCAN;
							end
							REQ_PEEK: begin
								rem_q <= CW'(1);
								state_q <= S_SCAN;
							end
							REQ_SHOW: begin
								rem_q <= (32'(count_q) > MaxShow) ? CW'(MaxShow) : count_q;
								state_q <= S_SCAN;
							end
							REQ_SEARCH: begin
								rem_q <= count_q;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
					if (mem_we) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_SCAN: begin
					if (mem_re) begin
						rem_q <= rem_q - CW'(1);
						pend_q <= 1'b1;
					end else if (consume) begin
						pend_q <= 1'b0;
					end
					if (done) begin
						rem_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan payload: pointer, direction, key and slot of the word in flight
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= value;
			search_q <= (req_type == REQ_SEARCH);
			down_q <= (req_type != REQ_SEARCH);
			ptr_q <= (req_type == REQ_SEARCH) ? '0 : cnt_dec[AW-1:0];
		end else if (mem_re) begin
			ptr_q <= down_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
			pend_slot_s1 <= ptr_q;
			pend_last_s1 <= (rem_q == CW'(1));
		end
	end

	stk_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(value),
		.re(mem_re),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	stk_oreg u_oreg (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.res_in(res_in),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.can_load(can_emit),
		.res_q(res_q)
	);

	assign status = res_q.status;
	assign data = res_q.data;
	assign position = res_q.position;
	assign empty_res = res_q.empty_res;
	assign last = res_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("word count exceeds depth");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_emit)
		else $error("result produced while output register is blocked");

	a_scan_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (rem_q != '0 || pend_q))
		else $error("scan running with nothing left to read or deliver");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_q)
		else $error("word left in flight after scan ended");

endmodule
